[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Every check is sampled on the rising edge of clk and is switched off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge outside reset.
`define JNDC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The condition must never be true at a sampled edge outside reset.
`define JNDC_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/core/jndc_pkg.sv]
package jndc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned DEPTH_W = 8;

	localparam logic [DEPTH_W-1:0] MAX_DEPTH_RESET = 8'd64;

	localparam logic [BYTE_W-1:0] CH_OPEN_BRACE    = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_OPEN_BRACKET  = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_CLOSE_BRACE   = 8'h7D;
	localparam logic [BYTE_W-1:0] CH_CLOSE_BRACKET = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_QUOTE         = 8'h22;
	localparam logic [BYTE_W-1:0] CH_BACKSLASH     = 8'h5C;

	// Classes of bytes that the scanner tells apart.
	typedef enum logic [2:0] {
		CLS_OTHER,
		CLS_QUOTE,
		CLS_BACKSLASH,
		CLS_OPEN,
		CLS_CLOSE
	} byte_class_t;

	// Scanner state carried from one byte of a message to the next.
	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic               quoted;
		logic               escape;
		logic               failed;
	} scan_state_t;

	localparam scan_state_t SCAN_CLEAR = '{depth: '0, quoted: 1'b0, escape: 1'b0,
		failed: 1'b0};

	function automatic byte_class_t classify(input logic [BYTE_W-1:0] b);
		byte_class_t cls;
		case (b) inside
			CH_OPEN_BRACE, CH_OPEN_BRACKET:   cls = CLS_OPEN;
			CH_CLOSE_BRACE, CH_CLOSE_BRACKET: cls = CLS_CLOSE;
			CH_QUOTE:                         cls = CLS_QUOTE;
			CH_BACKSLASH:                     cls = CLS_BACKSLASH;
			default:                          cls = CLS_OTHER;
		endcase
		return cls;
	endfunction

	// One step of the scanner. Once a message has failed, nothing changes until it ends.
	function automatic scan_state_t scan_next(input scan_state_t st,
			input logic [BYTE_W-1:0] b, input logic [DEPTH_W-1:0] max_depth);
		scan_state_t nxt;
		byte_class_t cls;
		logic [DEPTH_W:0] inc;
		nxt = st;
		cls = classify(b);
		inc = {1'b0, st.depth} + {{DEPTH_W{1'b0}}, 1'b1};
		if (!st.failed) begin
			if (st.quoted) begin
				if (st.escape) begin
					nxt.escape = 1'b0;
				end else if (cls == CLS_BACKSLASH) begin
					nxt.escape = 1'b1;
				end else if (cls == CLS_QUOTE) begin
					nxt.quoted = 1'b0;
				end
			end else begin
				case (cls)
					CLS_QUOTE: begin
						nxt.quoted = 1'b1;
					end
					CLS_OPEN: begin
						if (inc > {1'b0, max_depth}) begin
							nxt.failed = 1'b1;
						end else begin
							nxt.depth = inc[DEPTH_W-1:0];
						end
					end
					CLS_CLOSE: begin
						if (st.depth == '0) begin
							nxt.failed = 1'b1;
						end else begin
							nxt.depth = st.depth - {{(DEPTH_W-1){1'b0}}, 1'b1};
						end
					end
					default: begin
						nxt = st;
					end
				endcase
			end
		end
		return nxt;
	endfunction

endpackage

[rtl/core/json_nesting_depth_checker_top.sv]
// Channel   Direction  Handshake            Payload
// in        in         in_valid / in_ready  data_byte[7:0], last_byte
// out       out        out_valid/out_ready  message_ok
// cfg       in         cfg_wr_en            cfg_wr_data[7:0] (max_depth)
//
// One byte is taken per cycle unless the input is stalled. A byte is held in the input register
// and is scanned as it leaves it; the verdict of a final byte is loaded into the output register
// at that same edge, so out_valid rises as the final byte leaves the input register.
// Reset clears the scanner, both valid flags and sets max_depth to 64.
// Only a final byte needs room in the output register, so a held verdict stalls the input
// only when the next final byte reaches the front; other bytes keep flowing.

`include "assert_macros.svh"

module json_nesting_depth_checker_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [jndc_pkg::BYTE_W-1:0]    data_byte,
	input  logic                           last_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           message_ok,
	input  logic                           cfg_wr_en,
	input  logic [jndc_pkg::DEPTH_W-1:0]   cfg_wr_data
);

	// Input register: one beat waiting to be scanned.
	logic                        valid_s1;
	logic [jndc_pkg::BYTE_W-1:0] byte_s1;
	logic                        last_s1;

	// Configured limit and the scanner state of the message in progress.
	logic [jndc_pkg::DEPTH_W-1:0] max_depth_q;
	jndc_pkg::scan_state_t        scan_q;
	jndc_pkg::scan_state_t        scan_d;

	// Output register holding one verdict.
	logic out_valid_q;
	logic message_ok_q;

	logic out_free;
	logic advance;
	logic last_go;

	// The output slot is free when it is empty or its verdict is being taken this cycle.
	assign out_free = !out_valid_q || out_ready;
	// The front byte moves on unless it is a final byte with nowhere to put its verdict.
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || advance;
	// A final byte leaves the input register and its verdict is loaded.
	assign last_go  = advance && last_s1;

	assign scan_d = jndc_pkg::scan_next(scan_q, byte_s1, max_depth_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_q <= jndc_pkg::MAX_DEPTH_RESET;
		end else if (cfg_wr_en) begin
			max_depth_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// The payload of the input register needs no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// The scanner state advances with each byte; a final byte also clears it for the next
	// message once its verdict has been formed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= jndc_pkg::SCAN_CLEAR;
		end else if (advance) begin
			if (last_s1) begin
				scan_q <= jndc_pkg::SCAN_CLEAR;
			end else begin
				scan_q <= scan_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The verdict is good only for a clean, closed and fully balanced message.
	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			message_ok_q <= !scan_d.failed && !scan_d.quoted && (scan_d.depth == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign message_ok = message_ok_q;

	// An escape can only be pending inside a string.
	`JNDC_NEVER(a_escape_in_string, scan_q.escape && !scan_q.quoted, "escape outside string")
	// A failed message keeps its depth until its final byte.
	`JNDC_ASSERT(a_failed_frozen, scan_q.failed && !last_go |=> $stable(scan_q.depth), "depth moved")
	// A final byte leaves the scanner clear for the next message.
	`JNDC_ASSERT(a_clear_after_last, last_go |=> (scan_q == jndc_pkg::SCAN_CLEAR), "not cleared")
	// A verdict only appears after a final byte was scanned.
	`JNDC_ASSERT(a_verdict_source, $rose(out_valid_q) |-> $past(last_go), "verdict without final")

endmodule
